>>> rtl/core/trilinear_voxel_interpolator_core_assert.svh
// Assertion macros shared by the trilinear voxel interpolator RTL.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef TRILINEAR_VOXEL_INTERPOLATOR_CORE_ASSERT_SVH
`define TRILINEAR_VOXEL_INTERPOLATOR_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define TVI_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define TVI_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define TVI_ASSERT(lbl, clk, rstn, prop, msg)
`define TVI_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

>>> rtl/core/tvi_pkg.sv
// Package for the trilinear voxel interpolator: widths, register indexes,
// microcode word format and the microcode program. No dependencies.
`default_nettype none

package tvi_pkg;

    localparam int VOLUME_DEPTH_DEF = 65536;
    localparam int FRAC_BITS_DEF    = 16;

    localparam int COORD_W   = 8;
    localparam int STRIDE_W  = 16;
    localparam int VOXEL_W   = 16;
    localparam int FRAC_IN_W = 16;
    localparam int WADDR_W   = 16;
    localparam int PROD_W    = COORD_W + STRIDE_W;
    localparam int SUM_W     = PROD_W + 2;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_Z = 2'd2;

    localparam logic [STRIDE_W-1:0] STRIDE_X_RST = 16'd1;
    localparam logic [STRIDE_W-1:0] STRIDE_Y_RST = 16'd256;
    localparam logic [STRIDE_W-1:0] STRIDE_Z_RST = 16'd65535;

    localparam int STEP_W = 6;
    localparam logic [STEP_W-1:0] S_DISPATCH = 6'd0;
    localparam logic [STEP_W-1:0] S_READ0    = 6'd1;
    localparam logic [STEP_W-1:0] S_CHECK    = 6'd9;
    localparam logic [STEP_W-1:0] S_BLEND0   = 6'd10;
    localparam logic [STEP_W-1:0] S_OUT      = 6'd38;
    localparam logic [STEP_W-1:0] S_WRITE    = 6'd39;

    localparam int RF_N     = 14;
    localparam int RF_IDX_W = 4;
    localparam int BLEND_N  = 7;

    localparam logic [RF_IDX_W-1:0] BLEND_LO  [BLEND_N] = '{
        4'd0, 4'd2, 4'd4, 4'd6, 4'd8, 4'd10, 4'd12};
    localparam logic [RF_IDX_W-1:0] BLEND_HI  [BLEND_N] = '{
        4'd1, 4'd3, 4'd5, 4'd7, 4'd9, 4'd11, 4'd13};
    localparam logic [RF_IDX_W-1:0] BLEND_DST [BLEND_N] = '{
        4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd0};

    typedef enum logic [1:0] {
        J_NONE,
        J_WRITE,
        J_ERR
    } jcond_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    typedef struct packed {
        logic                prod_en;
        logic                rd_en;
        logic [2:0]          corner;
        logic                mac_en;
        logic                clr;
        logic                half;
        logic                hi_w;
        axis_t               axis;
        logic [RF_IDX_W-1:0] src;
        logic                st_en;
        logic                st_shr;
        logic [RF_IDX_W-1:0] dst;
        logic                wr_en;
        logic                out_en;
        jcond_t              jc;
        logic [STEP_W-1:0]   target;
        logic                last;
    } uword_t;

    typedef struct packed {
        logic   load;
        uword_t uw;
    } dp_ctl_t;

    typedef struct packed {
        logic is_write;
        logic err;
        logic out_full;
    } dp_stat_t;

    // Microcode program. Each blend takes four steps: low half and high half of
    // the lower operand times its weight, then the same for the upper operand.
    function automatic uword_t ucode(input logic [STEP_W-1:0] step);
        uword_t            w;
        logic [STEP_W-1:0] rel;
        logic [2:0]        blk;
        logic [1:0]        ph;
        w   = '0;
        rel = step - S_BLEND0;
        blk = rel[4:2];
        ph  = rel[1:0];
        if (step == S_DISPATCH) begin
            w.prod_en = 1'b1;
            w.jc      = J_WRITE;
            w.target  = S_WRITE;
        end else if (step >= S_READ0 && step < S_CHECK) begin
            w.rd_en  = 1'b1;
            w.corner = 3'(step - S_READ0);
        end else if (step == S_CHECK) begin
            w.jc     = J_ERR;
            w.target = S_OUT;
        end else if (step >= S_BLEND0 && step < S_OUT) begin
            w.mac_en = 1'b1;
            w.clr    = (ph == 2'd0);
            w.half   = ph[0];
            w.hi_w   = ph[1];
            w.src    = ph[1] ? BLEND_HI[blk] : BLEND_LO[blk];
            w.axis   = (blk < 3'd4) ? AX_X : ((blk < 3'd6) ? AX_Y : AX_Z);
            if (ph == 2'd3 && blk != 3'd6) begin
                w.st_en  = 1'b1;
                w.st_shr = (blk >= 3'd4);
                w.dst    = BLEND_DST[blk];
            end
        end else if (step == S_OUT) begin
            w.out_en = 1'b1;
            w.last   = 1'b1;
        end else if (step == S_WRITE) begin
            w.wr_en = 1'b1;
            w.last  = 1'b1;
        end
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/trilinear_voxel_interpolator_core.sv
// Top level of the trilinear voxel interpolator.
// Depends on tvi_pkg, tvi_sequencer and tvi_datapath.
//
// Requests arrive on the s_ channel (valid/ready). A request with s_action low
// writes s_write_value into the volume store and gives no result; it keeps the
// block busy through its dispatch and write steps. A request with s_action high
// interpolates a point from eight corner voxels and gives one result on the m_
// channel (valid/ready): m_value and m_range_error. An interpolation runs the
// microcode program from acceptance to m_valid, jumping past the blends when a
// corner lies beyond the store, and no new request is taken until the program
// ends. The program makes eight reads through the single volume store port,
// then seven blends of four multiply-accumulate steps each on one shared
// multiplier. Stride registers are written through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while idle, which the block does not enforce.
// Synchronous reset (aresetn low) returns the sequencer to idle, drops m_valid
// and loads the stride reset values; the volume store keeps undefined contents
// until written. While the receiver holds m_ready low, a finished result waits
// in the output register; the next request is still taken and runs until its
// own result is ready, then waits for the register to empty.
`default_nettype none

module trilinear_voxel_interpolator_core
    import tvi_pkg::*;
#(
    parameter int VOLUME_DEPTH = VOLUME_DEPTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STRIDE_W-1:0]  cfg_wdata,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_action,
    input  logic [WADDR_W-1:0]   s_write_address,
    input  logic [VOXEL_W-1:0]   s_write_value,
    input  logic [COORD_W-1:0]   s_lo_x,
    input  logic [COORD_W-1:0]   s_lo_y,
    input  logic [COORD_W-1:0]   s_lo_z,
    input  logic [COORD_W-1:0]   s_hi_x,
    input  logic [COORD_W-1:0]   s_hi_y,
    input  logic [COORD_W-1:0]   s_hi_z,
    input  logic [FRAC_IN_W-1:0] s_frac_x,
    input  logic [FRAC_IN_W-1:0] s_frac_y,
    input  logic [FRAC_IN_W-1:0] s_frac_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VOXEL_W-1:0]   m_value,
    output logic                 m_range_error
);

    dp_ctl_t  ctl;
    dp_stat_t stat;

    tvi_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .ctl     (ctl)
    );

    tvi_datapath #(
        .VOLUME_DEPTH (VOLUME_DEPTH),
        .FRAC_BITS    (FRAC_BITS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_action        (s_action),
        .s_write_address (s_write_address),
        .s_write_value   (s_write_value),
        .s_lo_x          (s_lo_x),
        .s_lo_y          (s_lo_y),
        .s_lo_z          (s_lo_z),
        .s_hi_x          (s_hi_x),
        .s_hi_y          (s_hi_y),
        .s_hi_z          (s_hi_z),
        .s_frac_x        (s_frac_x),
        .s_frac_y        (s_frac_y),
        .s_frac_z        (s_frac_z),
        .ctl             (ctl),
        .stat            (stat),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_value         (m_value),
        .m_range_error   (m_range_error)
    );

endmodule

`default_nettype wire

>>> rtl/core/tvi_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module tvi_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> rtl/core/tvi_sequencer.sv
// Microcode sequencer: step counter, program lookup and conditional jumps.
// Depends on tvi_pkg and the assertion macro header.
`default_nettype none
`include "trilinear_voxel_interpolator_core_assert.svh"

module tvi_sequencer
    import tvi_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_ctl_t  ctl
);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    uword_t            uw;
    logic              accept;
    logic              hold;
    logic              take_jump;

    always_comb begin
        accept = s_valid && (state_reg == ST_IDLE);
        uw     = (state_reg == ST_RUN) ? ucode(step_reg) : '0;
        hold   = uw.out_en && stat.out_full;
        case (uw.jc)
            J_WRITE: take_jump = stat.is_write;
            J_ERR:   take_jump = stat.err;
            default: take_jump = 1'b0;
        endcase
        state_next = state_reg;
        step_next  = step_reg;
        if (accept) begin
            state_next = ST_RUN;
            step_next  = S_DISPATCH;
        end else if (state_reg == ST_RUN && !hold) begin
            if (take_jump) begin
                step_next = uw.target;
            end else if (uw.last) begin
                state_next = ST_IDLE;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= S_DISPATCH;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign s_ready  = (state_reg == ST_IDLE);
    assign ctl.load = accept;
    assign ctl.uw   = uw;

    `TVI_ASSERT(a_accept_start, aclk, aresetn, accept |=> (state_reg == ST_RUN && step_reg == S_DISPATCH), "accepted request did not start the program")
    `TVI_ASSERT(a_out_hold, aclk, aresetn, hold |=> (state_reg == ST_RUN && step_reg == S_OUT), "stalled result step was left")
    `TVI_ASSERT(a_step_range, aclk, aresetn, (state_reg == ST_RUN) |-> (step_reg <= S_WRITE), "step counter beyond program")

endmodule

`default_nettype wire

>>> rtl/core/tvi_datapath.sv
// Datapath: stride registers, request capture, address products, volume store,
// operand register file, shared multiply-accumulate and result register.
// Depends on tvi_pkg, tvi_ram and the assertion macro header.
`default_nettype none
`include "trilinear_voxel_interpolator_core_assert.svh"

module tvi_datapath
    import tvi_pkg::*;
#(
    parameter int VOLUME_DEPTH = VOLUME_DEPTH_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [STRIDE_W-1:0]  cfg_wdata,
    input  logic                 s_action,
    input  logic [WADDR_W-1:0]   s_write_address,
    input  logic [VOXEL_W-1:0]   s_write_value,
    input  logic [COORD_W-1:0]   s_lo_x,
    input  logic [COORD_W-1:0]   s_lo_y,
    input  logic [COORD_W-1:0]   s_lo_z,
    input  logic [COORD_W-1:0]   s_hi_x,
    input  logic [COORD_W-1:0]   s_hi_y,
    input  logic [COORD_W-1:0]   s_hi_z,
    input  logic [FRAC_IN_W-1:0] s_frac_x,
    input  logic [FRAC_IN_W-1:0] s_frac_y,
    input  logic [FRAC_IN_W-1:0] s_frac_z,
    input  dp_ctl_t              ctl,
    output dp_stat_t             stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [VOXEL_W-1:0]   m_value,
    output logic                 m_range_error
);

    localparam int ADDR_W = $clog2(VOLUME_DEPTH);
    localparam int AW     = VOXEL_W + FRAC_BITS;
    localparam int ACC_W  = VOXEL_W + 2 * FRAC_BITS;
    localparam int HALF_W = (AW + 1) / 2;
    localparam int W_W    = FRAC_BITS + 1;
    localparam int PP_W   = HALF_W + W_W;
    localparam logic [SUM_W-1:0] DEPTH_LIM = SUM_W'(VOLUME_DEPTH);
    localparam logic [W_W-1:0]   ONE_W     = W_W'(1) << FRAC_BITS;

    uword_t uw;
    assign uw = ctl.uw;

    logic [STRIDE_W-1:0]  stride_x_reg, stride_y_reg, stride_z_reg;
    logic                 action_reg;
    logic [WADDR_W-1:0]   waddr_reg;
    logic [VOXEL_W-1:0]   wvalue_reg;
    logic [COORD_W-1:0]   lo_x_reg, lo_y_reg, lo_z_reg, hi_x_reg, hi_y_reg, hi_z_reg;
    logic [FRAC_IN_W-1:0] frac_x_reg, frac_y_reg, frac_z_reg;
    logic [PROD_W-1:0]    px0_reg, px1_reg, py0_reg, py1_reg, pz0_reg, pz1_reg;
    logic                 err_reg;
    logic                 rd_pend_reg;
    logic [2:0]           rd_idx_reg;
    logic [AW-1:0]        rf_reg [RF_N];
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic                 m_valid_reg;
    logic [VOXEL_W-1:0]   m_value_reg;
    logic                 m_range_error_reg;

    logic [SUM_W-1:0]     corner_sum;
    logic                 waddr_ok;
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_addr;
    logic [VOXEL_W-1:0]   ram_rdata;
    logic [AW-1:0]        op_a;
    logic [HALF_W-1:0]    a_half;
    logic [FRAC_BITS-1:0] f;
    logic [W_W-1:0]       w;
    logic [PP_W-1:0]      pp;
    logic [ACC_W-1:0]     pp_sh;
    logic [AW-1:0]        st_val;
    logic                 out_full;
    logic                 load_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stride_x_reg <= STRIDE_X_RST;
            stride_y_reg <= STRIDE_Y_RST;
            stride_z_reg <= STRIDE_Z_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_STRIDE_X: stride_x_reg <= cfg_wdata;
                CFG_STRIDE_Y: stride_y_reg <= cfg_wdata;
                CFG_STRIDE_Z: stride_z_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            action_reg <= s_action;
            waddr_reg  <= s_write_address;
            wvalue_reg <= s_write_value;
            lo_x_reg   <= s_lo_x;
            lo_y_reg   <= s_lo_y;
            lo_z_reg   <= s_lo_z;
            hi_x_reg   <= s_hi_x;
            hi_y_reg   <= s_hi_y;
            hi_z_reg   <= s_hi_z;
            frac_x_reg <= s_frac_x;
            frac_y_reg <= s_frac_y;
            frac_z_reg <= s_frac_z;
        end
        if (uw.prod_en) begin
            px0_reg <= PROD_W'(lo_x_reg) * PROD_W'(stride_x_reg);
            px1_reg <= PROD_W'(hi_x_reg) * PROD_W'(stride_x_reg);
            py0_reg <= PROD_W'(lo_y_reg) * PROD_W'(stride_y_reg);
            py1_reg <= PROD_W'(hi_y_reg) * PROD_W'(stride_y_reg);
            pz0_reg <= PROD_W'(lo_z_reg) * PROD_W'(stride_z_reg);
            pz1_reg <= PROD_W'(hi_z_reg) * PROD_W'(stride_z_reg);
        end
    end

    always_comb begin
        corner_sum = SUM_W'(uw.corner[0] ? px1_reg : px0_reg)
                   + SUM_W'(uw.corner[1] ? py1_reg : py0_reg)
                   + SUM_W'(uw.corner[2] ? pz1_reg : pz0_reg);
        waddr_ok   = SUM_W'(waddr_reg) < DEPTH_LIM;
        ram_we     = uw.wr_en && waddr_ok;
        ram_addr   = uw.wr_en ? ADDR_W'(waddr_reg) : corner_sum[ADDR_W-1:0];
    end

    tvi_ram #(
        .WIDTH (VOXEL_W),
        .DEPTH (VOLUME_DEPTH)
    ) u_volume (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (wvalue_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        op_a   = rf_reg[uw.src];
        a_half = uw.half ? HALF_W'(op_a >> HALF_W) : op_a[HALF_W-1:0];
        case (uw.axis)
            AX_X:    f = FRAC_BITS'(frac_x_reg);
            AX_Y:    f = FRAC_BITS'(frac_y_reg);
            AX_Z:    f = FRAC_BITS'(frac_z_reg);
            default: f = '0;
        endcase
        w        = uw.hi_w ? {1'b0, f} : (ONE_W - {1'b0, f});
        pp       = a_half * w;
        pp_sh    = uw.half ? (ACC_W'(pp) << HALF_W) : ACC_W'(pp);
        acc_next = uw.clr ? pp_sh : (acc_reg + pp_sh);
        st_val   = uw.st_shr ? AW'(acc_next >> FRAC_BITS) : AW'(acc_next);
        out_full = m_valid_reg && !m_ready;
        load_out = uw.out_en && !out_full;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_reg     <= 1'b0;
            rd_pend_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (uw.prod_en) begin
                err_reg <= 1'b0;
            end else if (uw.rd_en && corner_sum >= DEPTH_LIM) begin
                err_reg <= 1'b1;
            end
            rd_pend_reg <= uw.rd_en;
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (uw.rd_en) begin
            rd_idx_reg <= uw.corner;
        end
        if (rd_pend_reg) begin
            rf_reg[RF_IDX_W'(rd_idx_reg)] <= AW'(ram_rdata);
        end else if (uw.mac_en && uw.st_en) begin
            rf_reg[uw.dst] <= st_val;
        end
        if (uw.mac_en) begin
            acc_reg <= acc_next;
        end
        if (load_out) begin
            m_value_reg       <= err_reg ? '0 : acc_reg[2*FRAC_BITS +: VOXEL_W];
            m_range_error_reg <= err_reg;
        end
    end

    assign stat.is_write  = !action_reg;
    assign stat.err       = err_reg;
    assign stat.out_full  = out_full;
    assign m_valid        = m_valid_reg;
    assign m_value        = m_value_reg;
    assign m_range_error  = m_range_error_reg;

    `TVI_NEVER(a_rf_one_write, aclk, aresetn, rd_pend_reg && uw.mac_en && uw.st_en, "read data and blend store collide")
    `TVI_ASSERT(a_err_zero, aclk, aresetn, (m_valid_reg && m_range_error_reg) |-> (m_value_reg == '0), "range error with nonzero value")
    `TVI_ASSERT(a_out_load, aclk, aresetn, load_out |=> m_valid_reg, "result load did not raise valid")

endmodule

`default_nettype wire
